// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes, result structure and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    // Operand fields are sign-extended from this many low bits.
    localparam int OPERAND_WIDTH = 32;
    localparam int IN_W          = 32;
    localparam int DATA_W        = 64;

    // Operation codes.
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // Status and data returned by the reduction unit.
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } t_red_out;

    // Sign-extend the low operand bits of an input field to the datapath width.
    function automatic logic signed [DATA_W-1:0] sext_operand(input logic [IN_W-1:0] raw);
        return {{(DATA_W-OPERAND_WIDTH){raw[OPERAND_WIDTH-1]}}, raw[OPERAND_WIDTH-1:0]};
    endfunction

    // Magnitude of a value known to lie within plus or minus 2^31.
    function automatic logic [31:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] t;
        t = v[DATA_W-1] ? (~v + 64'd1) : v;
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/rau_mul.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Signed product of two small operands through one 32x32 magnitude multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_b,
    output logic                                 o_done,
    output logic signed [rau_pkg::DATA_W-1:0]    o_prod
);
    import rau_pkg::*;

    logic              r_v;
    logic              r_neg;
    logic [DATA_W-1:0] r_prod;

    // The magnitude product is registered; the sign is applied on the way out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_start;
        end
        if (i_start) begin
            r_prod <= DATA_W'(mag32(i_a)) * DATA_W'(mag32(i_b));
            r_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
        end
    end

    assign o_done = r_v;
    assign o_prod = r_neg ? -$signed(r_prod) : $signed(r_prod);

endmodule

`default_nettype wire

// ===== sv/rau_reduce.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit reduction
// Normalizes a fraction: binary gcd, then exact division of both parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_reduce (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_num,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_den,
    output rau_pkg::t_red_out                      o_res
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_GCD  = 4'b0010,
        R_DIV  = 4'b0100,
        R_DONE = 4'b1000
    } t_rstate;

    t_rstate           r_state, n_state;
    logic              r_neg, n_neg;
    logic [DATA_W-1:0] r_nmag, n_nmag;
    logic [DATA_W-1:0] r_dmag, n_dmag;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_y, n_y;
    logic [6:0]        r_k, n_k;
    logic [DATA_W-1:0] r_g, n_g;
    logic [DATA_W-1:0] r_rn, n_rn;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic [5:0]        r_cnt, n_cnt;

    logic signed [DATA_W-1:0] s_nn, s_dd;
    logic [DATA_W:0]          s_diff;
    logic [DATA_W:0]          s_rn_sh, s_rd_sh;
    logic [DATA_W-1:0]        s_g;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_nmag  = r_nmag;
        n_dmag  = r_dmag;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_rn    = r_rn;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        s_nn    = (i_den < 0) ? -i_num : i_num;
        s_dd    = (i_den < 0) ? -i_den : i_den;
        s_diff  = {1'b0, r_x} - {1'b0, r_y};
        s_rn_sh = {r_rn, r_nmag[DATA_W-1]};
        s_rd_sh = {r_rd, r_dmag[DATA_W-1]};
        s_g     = (r_x == '0) ? (r_y << r_k) : (r_x << r_k);

        case (r_state)
            // Make the denominator non-negative and split off the sign.
            R_IDLE: begin
                if (i_start) begin
                    n_neg   = s_nn[DATA_W-1];
                    n_nmag  = s_nn[DATA_W-1] ? DATA_W'(-s_nn) : DATA_W'(s_nn);
                    n_dmag  = DATA_W'(s_dd);
                    n_x     = n_nmag;
                    n_y     = n_dmag;
                    n_k     = '0;
                    n_state = R_GCD;
                end
            end
            // One binary gcd step per cycle.
            R_GCD: begin
                if (r_x == '0 || r_y == '0) begin
                    n_g   = s_g;
                    n_rn  = '0;
                    n_rd  = '0;
                    n_cnt = '0;
                    if (s_g == '0) begin
                        n_neg   = 1'b0;
                        n_nmag  = '0;
                        n_dmag  = DATA_W'(1);
                        n_state = R_DONE;
                    end else begin
                        n_state = R_DIV;
                    end
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 7'd1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!s_diff[DATA_W]) begin
                    n_x = s_diff[DATA_W-1:0] >> 1;
                end else begin
                    n_y = DATA_W'(-s_diff) >> 1;
                end
            end
            // Restoring division of both magnitudes by the gcd, one bit a cycle.
            R_DIV: begin
                if (s_rn_sh >= {1'b0, r_g}) begin
                    n_rn   = DATA_W'(s_rn_sh - {1'b0, r_g});
                    n_nmag = {r_nmag[DATA_W-2:0], 1'b1};
                end else begin
                    n_rn   = s_rn_sh[DATA_W-1:0];
                    n_nmag = {r_nmag[DATA_W-2:0], 1'b0};
                end
                if (s_rd_sh >= {1'b0, r_g}) begin
                    n_rd   = DATA_W'(s_rd_sh - {1'b0, r_g});
                    n_dmag = {r_dmag[DATA_W-2:0], 1'b1};
                end else begin
                    n_rd   = s_rd_sh[DATA_W-1:0];
                    n_dmag = {r_dmag[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = R_DONE;
                end
            end
            R_DONE: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg  <= n_neg;
        r_nmag <= n_nmag;
        r_dmag <= n_dmag;
        r_x    <= n_x;
        r_y    <= n_y;
        r_k    <= n_k;
        r_g    <= n_g;
        r_rn   <= n_rn;
        r_rd   <= n_rd;
        r_cnt  <= n_cnt;
    end

    assign o_res.done = (r_state == R_DONE);
    assign o_res.num  = r_neg ? -$signed(r_nmag) : $signed(r_nmag);
    assign o_res.den  = $signed(r_dmag);

endmodule

`default_nettype wire

// ===== sv/rational_arithmetic_unit.sv =====
// Sequence from acceptance to o_valid: reduce operand a, then operand b (each
// a binary gcd followed by a bit-serial divide), four products on the shared
// multiplier, and a reduction of the result.
// Throughput: one word at a time; i_valid is taken only when the unit is idle.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply or divide two fractions with gcd reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_res_num,
    output logic [62:0]      o_res_den,
    output logic             o_is_less,
    output logic             o_is_equal,
    output logic             o_den_zero
);
    import rau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RA   = 6'b000010,
        S_RB   = 6'b000100,
        S_MUL  = 6'b001000,
        S_RR   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                   r_state;
    logic                     r_go;
    logic                     r_mgo;
    logic [1:0]               r_mcnt;
    logic [1:0]               r_mode;
    logic signed [DATA_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [DATA_W-1:0] r_left, r_right, r_p2;
    logic signed [DATA_W-1:0] r_rnum, r_rden;
    logic signed [DATA_W-1:0] r_resn, r_resd;
    logic                     r_less, r_eq, r_dz;

    t_red_out                 s_red;
    logic signed [DATA_W-1:0] s_red_num, s_red_den;
    logic signed [DATA_W-1:0] s_ma, s_mb, s_x, s_y;
    logic                     s_mdone;
    logic signed [DATA_W-1:0] s_prod;

    // Reduction input follows the sequencer step.
    always_comb begin
        case (r_state)
            S_RA: begin
                s_red_num = r_an;
                s_red_den = r_ad;
            end
            S_RB: begin
                s_red_num = r_bn;
                s_red_den = r_bd;
            end
            default: begin
                s_red_num = r_rnum;
                s_red_den = r_rden;
            end
        endcase
    end

    // Divide uses the inverse of b, whose sign moves to the numerator.
    always_comb begin
        if (r_mode == MODE_DIV) begin
            s_x = (r_bn < 0) ? -r_bd : r_bd;
            s_y = (r_bn < 0) ? -r_bn : r_bn;
        end else begin
            s_x = r_bn;
            s_y = r_bd;
        end
        case (r_mcnt)
            2'd0: begin
                s_ma = r_an;
                s_mb = r_bd;
            end
            2'd1: begin
                s_ma = r_bn;
                s_mb = r_ad;
            end
            2'd2: begin
                s_ma = r_an;
                s_mb = s_x;
            end
            default: begin
                s_ma = r_ad;
                s_mb = s_y;
            end
        endcase
    end

    rau_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_num   (s_red_num),
        .i_den   (s_red_den),
        .o_res   (s_red)
    );

    rau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mgo),
        .i_a     (s_ma),
        .i_b     (s_mb),
        .o_done  (s_mdone),
        .o_prod  (s_prod)
    );

    // Sequencer: reduce a, reduce b, four products, reduce the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_mgo   <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_go  <= 1'b0;
            r_mgo <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= i_mode;
                        r_an    <= sext_operand(i_a_num);
                        r_ad    <= sext_operand(i_a_den);
                        r_bn    <= sext_operand(i_b_num);
                        r_bd    <= sext_operand(i_b_den);
                        r_go    <= 1'b1;
                        r_state <= S_RA;
                    end
                end
                S_RA: begin
                    if (s_red.done) begin
                        r_an    <= s_red.num;
                        r_ad    <= s_red.den;
                        r_go    <= 1'b1;
                        r_state <= S_RB;
                    end
                end
                S_RB: begin
                    if (s_red.done) begin
                        r_bn    <= s_red.num;
                        r_bd    <= s_red.den;
                        r_mcnt  <= '0;
                        r_mgo   <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (s_mdone) begin
                        case (r_mcnt)
                            2'd0: r_left  <= s_prod;
                            2'd1: r_right <= s_prod;
                            2'd2: r_p2    <= s_prod;
                            default: begin
                                case (r_mode)
                                    MODE_ADD: r_rnum <= r_left + r_right;
                                    MODE_SUB: r_rnum <= r_left - r_right;
                                    default:  r_rnum <= r_p2;
                                endcase
                                r_rden <= s_prod;
                                r_less <= (r_left < r_right);
                                r_eq   <= (r_an == r_bn) && (r_ad == r_bd);
                            end
                        endcase
                        if (r_mcnt == 2'd3) begin
                            r_go    <= 1'b1;
                            r_state <= S_RR;
                        end else begin
                            r_mcnt <= r_mcnt + 2'd1;
                            r_mgo  <= 1'b1;
                        end
                    end
                end
                S_RR: begin
                    if (s_red.done) begin
                        r_resn  <= s_red.num;
                        r_resd  <= s_red.den;
                        r_dz    <= (s_red.den == 0);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_res_num  = r_resn;
    assign o_res_den  = r_resd[62:0];
    assign o_is_less  = r_less;
    assign o_is_equal = r_eq;
    assign o_den_zero = r_dz;

endmodule

`default_nettype wire

// ===== bench/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs with random idle gaps and back-pressure, predicts each
// reduced result and comparison flag, and checks every output word in order.
// ----------------------------------------------------------------------------

module tb_rational_arithmetic_unit;

    import rau_pkg::*;

    localparam int HANG_LIMIT   = 20000;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        longint n;
        longint d;
    } frac_t;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        less;
        logic        equal;
        logic        zero;
    } rau_result_t;

    // Predicts results of accepted words and checks them against the outputs.
    class rau_scoreboard;
        rau_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Sign-extend the low operand bits of a field.
        function longint operand(logic [31:0] raw);
            logic [63:0] v;
            v = {32'd0, raw} << (64 - OPERAND_WIDTH);
            return longint'(v) >>> (64 - OPERAND_WIDTH);
        endfunction

        // Make the denominator non-negative and divide out the gcd.
        function frac_t reduce_frac(longint n, longint d);
            frac_t       f;
            logic [63:0] x, y, r;
            if (d < 0) begin
                n = -n;
                d = -d;
            end
            x = (n < 0) ? 64'(-n) : 64'(n);
            y = (d < 0) ? 64'(-d) : 64'(d);
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            if (x == 0) begin
                f.n = 0;
                f.d = 1;
            end else begin
                f.n = n / longint'(x);
                f.d = d / longint'(x);
            end
            return f;
        endfunction

        // Work out the result of one accepted word.
        function void note_word(logic [1:0] mode, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
            frac_t       a, b, q, inv;
            longint      left, right;
            rau_result_t e;
            a = reduce_frac(operand(an), operand(ad));
            b = reduce_frac(operand(bn), operand(bd));
            left  = a.n * b.d;
            right = b.n * a.d;
            case (mode)
                MODE_ADD: q = reduce_frac(left + right, a.d * b.d);
                MODE_SUB: q = reduce_frac(left - right, a.d * b.d);
                MODE_MUL: q = reduce_frac(a.n * b.n, a.d * b.d);
                default: begin
                    inv = reduce_frac(b.d, b.n);
                    q = reduce_frac(a.n * inv.n, a.d * inv.d);
                end
            endcase
            e.num   = q.n;
            e.den   = q.d[62:0];
            e.less  = left < right;
            e.equal = (a.n == b.n) && (a.d == b.d);
            e.zero  = q.d == 0;
            pending.push_back(e);
        endfunction

        // Compare one output word with the oldest prediction.
        function void check_word(rau_result_t got);
            rau_result_t e;
            if (pending.size() == 0) begin
                $error("result word with no prediction pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.num !== e.num) begin
                $error("res_num expected %0d got %0d", $signed(e.num), $signed(got.num));
                errors++;
            end
            if (got.den !== e.den) begin
                $error("res_den expected %0d got %0d", e.den, got.den);
                errors++;
            end
            if (got.less !== e.less) begin
                $error("is_less expected %0b got %0b", e.less, got.less);
                errors++;
            end
            if (got.equal !== e.equal) begin
                $error("is_equal expected %0b got %0b", e.equal, got.equal);
                errors++;
            end
            if (got.zero !== e.zero) begin
                $error("den_zero expected %0b got %0b", e.zero, got.zero);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [1:0]  i_mode = MODE_ADD;
    logic [31:0] i_a_num = '0;
    logic [31:0] i_a_den = '0;
    logic [31:0] i_b_num = '0;
    logic [31:0] i_b_den = '0;
    logic        o_ready, o_valid;
    logic [63:0] o_res_num;
    logic [62:0] o_res_den;
    logic        o_is_less, o_is_equal, o_den_zero;

    rau_scoreboard sb = new();
    int            words_out = 0;
    int            idle_cycles = 0;
    bit            pressure_done = 0;

    rational_arithmetic_unit uut (.*);

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one word after a random gap, which may be zero, and hold it until it is accepted.
    task automatic send_word(logic [1:0] mode, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(mode, an, ad, bn, bd);
        @(negedge i_clk);
    endtask

    // Operand value: small, boundary or full random.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($signed($urandom_range(0, 40)) - 20);
            3: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
            4, 5: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off so the unit backs up.
    initial begin
        rau_result_t got;
        int          stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!pressure_done && words_out == 100) begin
                stall = 1500;
                pressure_done = 1;
            end else begin
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.num   = o_res_num;
            got.den   = o_res_den;
            got.less  = o_is_less;
            got.equal = o_is_equal;
            got.zero  = o_den_zero;
            sb.check_word(got);
            words_out++;
            @(negedge i_clk);
        end
    end

    // Sender: directed corner words, then random words.
    initial begin
        logic [31:0] an, ad, bn, bd;
        int          k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(MODE_MUL, 32'hffff_fffe, 32'd4, 32'd6, 32'hffff_fff7);
        send_word(MODE_DIV, 32'd3, 32'd4, 32'hffff_fffe, 32'd5);
        send_word(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(MODE_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_word(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_word(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe);
        // Zero denominators and the zero-over-zero operand.
        send_word(MODE_ADD, 32'd5, 32'd0, 32'd1, 32'd2);
        send_word(MODE_SUB, 32'hffff_fffd, 32'd0, 32'd7, 32'd0);
        send_word(MODE_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
        send_word(MODE_ADD, 32'd0, 32'd0, 32'd3, 32'd0);
        // Divide by zero, with zero and nonzero dividend.
        send_word(MODE_DIV, 32'd3, 32'd7, 32'd0, 32'd9);
        send_word(MODE_DIV, 32'd0, 32'd7, 32'd0, 32'hffff_fff0);
        send_word(MODE_DIV, 32'd1, 32'd0, 32'd0, 32'd0);
        // Equal after reduction, and a negative denominator.
        send_word(MODE_SUB, 32'd6, 32'hfffffff8, 32'hfffffffd, 32'd4);
        send_word(MODE_ADD, 32'd2, 32'd4, 32'd1, 32'd2);
        send_word(MODE_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'd1);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            an = pick_operand();
            ad = pick_operand();
            if ($urandom_range(0, 4) == 0) begin
                // Same value scaled, so the equal flag gets exercised.
                k  = $urandom_range(1, 50);
                bn = an * k;
                bd = ad * k;
            end else begin
                bn = pick_operand();
                bd = pick_operand();
            end
            send_word(2'($urandom_range(0, 3)), an, ad, bn, bd);
        end
        i_valid <= 1'b0;

        wait (sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
